/* src/egr_pkg.sv */
// ---------------------------------------------------------------------------
// egr_pkg: shared types and constants for the emitter group recolour block
// Lane count, level widths, pipeline depth and the payload structures.
// ---------------------------------------------------------------------------
package egr_pkg;

  localparam int LANES     = 6;
  localparam int FIELDS    = 6;
  localparam int ACT_LANES = (LANES < FIELDS) ? LANES : FIELDS;
  localparam int LVL_W     = 8;
  localparam int NUM_W     = 2 * LVL_W;
  localparam int DIV_BITS  = LVL_W;
  // One stage for the peaks, one for the product, one per quotient bit.
  localparam int NSTG      = 2 + DIV_BITS;

  typedef logic [LVL_W-1:0] lvl_t;
  typedef lvl_t [FIELDS-1:0] lvl_vec_t;
  typedef logic [NUM_W-1:0] num_t;

  typedef struct packed {
    logic [NSTG-1:0] en;
  } egr_ctl_t;

  typedef struct packed {
    logic [7:0] show_lane0;
    logic [7:0] show_lane1;
    logic [7:0] show_lane2;
    logic [7:0] show_lane3;
    logic [7:0] show_lane4;
    logic [7:0] show_lane5;
    logic [7:0] tmpl_lane0;
    logic [7:0] tmpl_lane1;
    logic [7:0] tmpl_lane2;
    logic [7:0] tmpl_lane3;
    logic [7:0] tmpl_lane4;
    logic [7:0] tmpl_lane5;
  } egr_in_t;

  typedef struct packed {
    logic [7:0] out_lane0;
    logic [7:0] out_lane1;
    logic [7:0] out_lane2;
    logic [7:0] out_lane3;
    logic [7:0] out_lane4;
    logic [7:0] out_lane5;
    logic       template_dark;
  } egr_out_t;

endpackage

/* src/egr_if.sv */
// ---------------------------------------------------------------------------
// egr_if: valid/ready channels of the emitter group recolour block
// One interface for the group beat going in, one for the result beat.
// ---------------------------------------------------------------------------
interface egr_in_if import egr_pkg::*; ();
  logic    valid;
  logic    ready;
  egr_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface egr_out_if import egr_pkg::*; ();
  logic     valid;
  logic     ready;
  egr_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* src/egr_peak.sv */
// ---------------------------------------------------------------------------
// egr_peak: merging stage over all lanes
// Finds the show and template peaks over the active lanes and registers
// them together with the lane levels.
// ---------------------------------------------------------------------------
module egr_peak import egr_pkg::*; (
  input  logic     clk,
  input  egr_ctl_t ctl,
  input  lvl_vec_t show,
  input  lvl_vec_t tmpl,
  output lvl_vec_t show_r,
  output lvl_vec_t tmpl_r,
  output lvl_t     speak_r,
  output lvl_t     tpeak_r
);

  lvl_t speak_nxt;
  lvl_t tpeak_nxt;

  always_comb begin
    speak_nxt = '0;
    tpeak_nxt = '0;
    for (int i = 0; i < FIELDS; i++) begin
      if (i < ACT_LANES) begin
        if (show[i] > speak_nxt) speak_nxt = show[i];
        if (tmpl[i] > tpeak_nxt) tpeak_nxt = tmpl[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en[0]) begin
      show_r  <= show;
      tmpl_r  <= tmpl;
      speak_r <= speak_nxt;
      tpeak_r <= tpeak_nxt;
    end
  end

endmodule

/* src/egr_lane.sv */
// ---------------------------------------------------------------------------
// egr_lane: one recolour lane
// Multiplies the template level by the show peak, adds half the template
// peak and divides by it in a restoring divider, one quotient bit a stage.
// ---------------------------------------------------------------------------
module egr_lane import egr_pkg::*; (
  input  logic     clk,
  input  egr_ctl_t ctl,
  input  logic     active,
  input  lvl_t     show,
  input  lvl_t     tmpl,
  input  lvl_t     speak,
  input  lvl_t     tpeak,
  output lvl_t     level
);

  num_t rem_r  [DIV_BITS];
  lvl_t q_r    [DIV_BITS+1];
  lvl_t den_r  [DIV_BITS+1];
  lvl_t show_r [DIV_BITS+1];

  // The template level never exceeds its peak, so the numerator stays below
  // the divisor times 256 and the quotient fits in eight bits.
  always_ff @(posedge clk) begin
    if (ctl.en[1]) begin
      rem_r[0]  <= num_t'(tmpl) * num_t'(speak) + num_t'(tpeak >> 1);
      q_r[0]    <= '0;
      den_r[0]  <= tpeak;
      show_r[0] <= show;
    end
  end

  for (genvar k = 1; k <= DIV_BITS; k++) begin : g_div
    localparam int B = DIV_BITS - k;
    num_t den_sh;
    logic ge;

    assign den_sh = num_t'(den_r[k-1]) << B;
    assign ge     = rem_r[k-1] >= den_sh;

    always_ff @(posedge clk) begin
      if (ctl.en[1+k]) begin
        q_r[k]    <= q_r[k-1] | (lvl_t'(ge) << B);
        den_r[k]  <= den_r[k-1];
        show_r[k] <= show_r[k-1];
      end
    end

    if (k < DIV_BITS) begin : g_rem
      always_ff @(posedge clk) begin
        if (ctl.en[1+k]) begin
          rem_r[k] <= ge ? (rem_r[k-1] - den_sh) : rem_r[k-1];
        end
      end
    end
  end

  // A dark template passes the show level through; the quotient is then junk.
  always_comb begin
    if (!active) begin
      level = '0;
    end else if (den_r[DIV_BITS] == '0) begin
      level = show_r[DIV_BITS];
    end else begin
      level = q_r[DIV_BITS];
    end
  end

endmodule

/* src/emitter_group_recolor.sv */
// A group beat accepted on the input is registered in the peak stage, then
// the product stage, then each divider stage; its result beat leaves from
// the last. Throughput: one group per cycle while the output does not
// stall; the per-lane divider is pipelined with one quotient bit per stage,
// so the peak, product and eight divider stages give ten stages in all.
// Stalls collapse bubbles stage by stage, so input stays open while any
// stage is empty. Reset (rst_n low, synchronous) empties the pipeline and
// holds the input closed.
// ---------------------------------------------------------------------------
// emitter_group_recolor: top level of the emitter group recolour block
// Peak merging stage followed by six parallel multiply and divide lanes.
// ---------------------------------------------------------------------------
module emitter_group_recolor import egr_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  egr_in_if.sink          in_ch,
  egr_out_if.source       out_ch
);

  egr_ctl_t        ctl;
  logic [NSTG:0]   rdy;
  logic [NSTG-1:0] v_r;
  logic [NSTG-1:0] v_nxt;
  logic [NSTG-1:1] dark_r;

  lvl_vec_t show;
  lvl_vec_t tmpl;
  lvl_vec_t show_r;
  lvl_vec_t tmpl_r;
  lvl_t     speak_r;
  lvl_t     tpeak_r;
  lvl_vec_t level;

  assign show[0] = in_ch.data.show_lane0;
  assign show[1] = in_ch.data.show_lane1;
  assign show[2] = in_ch.data.show_lane2;
  assign show[3] = in_ch.data.show_lane3;
  assign show[4] = in_ch.data.show_lane4;
  assign show[5] = in_ch.data.show_lane5;
  assign tmpl[0] = in_ch.data.tmpl_lane0;
  assign tmpl[1] = in_ch.data.tmpl_lane1;
  assign tmpl[2] = in_ch.data.tmpl_lane2;
  assign tmpl[3] = in_ch.data.tmpl_lane3;
  assign tmpl[4] = in_ch.data.tmpl_lane4;
  assign tmpl[5] = in_ch.data.tmpl_lane5;

  // A stage may load when it is empty or its contents move on this cycle.
  always_comb begin
    rdy[NSTG] = out_ch.ready;
    for (int i = NSTG - 1; i >= 0; i--) begin
      rdy[i] = !v_r[i] || rdy[i+1];
    end
  end

  assign ctl.en = rdy[NSTG-1:0];

  always_comb begin
    v_nxt[0] = rdy[0] ? in_ch.valid : v_r[0];
    for (int i = 1; i < NSTG; i++) begin
      v_nxt[i] = rdy[i] ? v_r[i-1] : v_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en[1]) dark_r[1] <= (tpeak_r == '0);
    for (int i = 2; i < NSTG; i++) begin
      if (ctl.en[i]) dark_r[i] <= dark_r[i-1];
    end
  end

  egr_peak u_peak (
    .clk     (clk),
    .ctl     (ctl),
    .show    (show),
    .tmpl    (tmpl),
    .show_r  (show_r),
    .tmpl_r  (tmpl_r),
    .speak_r (speak_r),
    .tpeak_r (tpeak_r)
  );

  for (genvar l = 0; l < FIELDS; l++) begin : g_lane
    egr_lane u_lane (
      .clk    (clk),
      .ctl    (ctl),
      .active (1'(l < ACT_LANES)),
      .show   (show_r[l]),
      .tmpl   (tmpl_r[l]),
      .speak  (speak_r),
      .tpeak  (tpeak_r),
      .level  (level[l])
    );
  end

  assign in_ch.ready                = rdy[0] && rst_n;
  assign out_ch.valid               = v_r[NSTG-1];
  assign out_ch.data.out_lane0      = level[0];
  assign out_ch.data.out_lane1      = level[1];
  assign out_ch.data.out_lane2      = level[2];
  assign out_ch.data.out_lane3      = level[3];
  assign out_ch.data.out_lane4      = level[4];
  assign out_ch.data.out_lane5      = level[5];
  assign out_ch.data.template_dark  = dark_r[NSTG-1];

  a_bubble_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[0] && !v_r[1]) |=> v_r[1])
    else $error("beat in the peak stage did not move into an empty product stage");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (&v_r && !out_ch.ready) |-> !in_ch.ready)
    else $error("input open while the full pipeline is stalled");

  a_open_gap: assert property (@(posedge clk) disable iff (!rst_n)
    !(&v_r) |-> in_ch.ready)
    else $error("input closed although a pipeline stage is empty");

  a_accept_load: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> v_r[0])
    else $error("accepted beat missing from the peak stage");

endmodule

/* dv/tb_emitter_group_recolor.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_emitter_group_recolor: self-checking bench for the group recolour block
// Sends emitter groups over the valid/ready input channel and predicts each
// recoloured result from the show and template peaks. Results are compared
// lane by lane, in order, while both channel ends idle at varying rates.
// ---------------------------------------------------------------------------
module tb_emitter_group_recolor import egr_pkg::*;;

  logic clk = 1'b0;
  logic rst_n;

  egr_in_if  in_ch ();
  egr_out_if out_ch ();

  emitter_group_recolor u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  egr_out_t pending_results[$];
  int       mismatch_count = 0;
  int       gap_pct        = 0;
  int       stall_pct      = 0;
  int       hold_left      = 0;

  function automatic lvl_vec_t show_levels(egr_in_t g);
    lvl_vec_t v;
    v[0] = g.show_lane0; v[1] = g.show_lane1; v[2] = g.show_lane2;
    v[3] = g.show_lane3; v[4] = g.show_lane4; v[5] = g.show_lane5;
    return v;
  endfunction

  function automatic lvl_vec_t tmpl_levels(egr_in_t g);
    lvl_vec_t v;
    v[0] = g.tmpl_lane0; v[1] = g.tmpl_lane1; v[2] = g.tmpl_lane2;
    v[3] = g.tmpl_lane3; v[4] = g.tmpl_lane4; v[5] = g.tmpl_lane5;
    return v;
  endfunction

  function automatic lvl_vec_t result_levels(egr_out_t r);
    lvl_vec_t v;
    v[0] = r.out_lane0; v[1] = r.out_lane1; v[2] = r.out_lane2;
    v[3] = r.out_lane3; v[4] = r.out_lane4; v[5] = r.out_lane5;
    return v;
  endfunction

  function automatic egr_in_t build_group(lvl_vec_t s, lvl_vec_t t);
    egr_in_t g;
    g.show_lane0 = s[0]; g.show_lane1 = s[1]; g.show_lane2 = s[2];
    g.show_lane3 = s[3]; g.show_lane4 = s[4]; g.show_lane5 = s[5];
    g.tmpl_lane0 = t[0]; g.tmpl_lane1 = t[1]; g.tmpl_lane2 = t[2];
    g.tmpl_lane3 = t[3]; g.tmpl_lane4 = t[4]; g.tmpl_lane5 = t[5];
    return g;
  endfunction

  // Scales the template so that its peak lands on the show peak, rounding to
  // nearest; a dark template lets the show levels through untouched.
  function automatic egr_out_t recolour_group(egr_in_t g);
    lvl_vec_t show, tmpl, res;
    lvl_t     show_pk, tmpl_pk;
    num_t     num;
    egr_out_t r;
    show    = show_levels(g);
    tmpl    = tmpl_levels(g);
    show_pk = '0;
    tmpl_pk = '0;
    for (int i = 0; i < ACT_LANES; i++) begin
      if (show[i] > show_pk) show_pk = show[i];
      if (tmpl[i] > tmpl_pk) tmpl_pk = tmpl[i];
    end
    for (int i = 0; i < FIELDS; i++) begin
      res[i] = '0;
      if (i < ACT_LANES) begin
        if (tmpl_pk == '0) begin
          res[i] = show[i];
        end else begin
          num    = num_t'(tmpl[i]) * num_t'(show_pk) + num_t'(tmpl_pk / 2);
          res[i] = lvl_t'(num / num_t'(tmpl_pk));
        end
      end
    end
    r.out_lane0 = res[0]; r.out_lane1 = res[1]; r.out_lane2 = res[2];
    r.out_lane3 = res[3]; r.out_lane4 = res[4]; r.out_lane5 = res[5];
    r.template_dark = (tmpl_pk == '0);
    return r;
  endfunction

  function automatic void check_result(egr_out_t act);
    egr_out_t exp_r;
    lvl_vec_t exp_l, act_l;
    if (pending_results.size() == 0) begin
      $error("result beat arrived with no group outstanding");
      mismatch_count++;
      return;
    end
    exp_r = pending_results.pop_front();
    exp_l = result_levels(exp_r);
    act_l = result_levels(act);
    for (int i = 0; i < FIELDS; i++) begin
      if (act_l[i] !== exp_l[i]) begin
        $error("out_lane%0d expected %0d got %0d", i, exp_l[i], act_l[i]);
        mismatch_count++;
      end
    end
    if (act.template_dark !== exp_r.template_dark) begin
      $error("template_dark expected %0d got %0d", exp_r.template_dark,
             act.template_dark);
      mismatch_count++;
    end
  endfunction

  // Result side: checks every beat and decides ready for the next cycle.
  // A long hold-off, when requested, takes precedence over random stalls.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) check_result(out_ch.data);
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Called at a rising edge; returns at the edge where the beat is taken.
  // Valid is left high so that back-to-back beats need no toggle.
  task automatic send_group(egr_in_t g);
    while ($urandom_range(99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= g;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_results.push_back(recolour_group(g));
  endtask

  task automatic send_levels(lvl_vec_t s, lvl_vec_t t);
    send_group(build_group(s, t));
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic egr_in_t random_group();
    lvl_vec_t s, t;
    int       kind;
    kind = $urandom_range(9);
    for (int i = 0; i < FIELDS; i++) begin
      s[i] = lvl_t'($urandom_range(255));
      t[i] = lvl_t'($urandom_range(255));
    end
    case (kind)
      0: begin
        t = '0;
      end
      1: begin
        s[5] = '0;
        t[5] = '0;
      end
      2: begin
        for (int i = 0; i < FIELDS; i++) t[i] = lvl_t'($urandom_range(3));
      end
      3: begin
        t[$urandom_range(FIELDS - 1)] = 8'hFF;
      end
      4: begin
        for (int i = 0; i < FIELDS; i++) s[i] = lvl_t'($urandom_range(7));
      end
      default: ;
    endcase
    return build_group(s, t);
  endfunction

  task automatic test_corner_groups();
    lvl_vec_t s, t;
    gap_pct   = 0;
    stall_pct = 0;
    send_levels('0, '0);
    send_levels({6{8'hFF}}, '0);
    send_levels({8'h80, 8'h01, 8'hFF, 8'hAA, 8'h55, 8'h00}, '0);
    send_levels({6{8'hFF}}, {6{8'hFF}});
    send_levels('0, {6{8'hFF}});
    send_levels({8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0},
                {8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd1});
    send_levels({8'd250, 8'd3, 8'd9, 8'd1, 8'd0, 8'd7},
                {8'd200, 8'd100, 8'd100, 8'd100, 8'd100, 8'd100});
    // Exact halves round upwards.
    send_levels({8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255},
                {8'd1, 8'd2, 8'd1, 8'd0, 8'd1, 8'd1});
    send_levels({8'd0, 8'd100, 8'd0, 8'd0, 8'd0, 8'd0},
                {8'd3, 8'd2, 8'd1, 8'd0, 8'd1, 8'd2});
    send_levels({8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1},
                {8'd254, 8'd255, 8'd128, 8'd127, 8'd1, 8'd0});
    // Five-channel group: the sixth lane is zero on both sides.
    send_levels({8'd0, 8'd17, 8'd200, 8'd33, 8'd91, 8'd4},
                {8'd0, 8'd60, 8'd12, 8'd255, 8'd7, 8'd180});
    for (int k = 0; k < FIELDS; k++) begin
      s = '0;
      t = {6{8'd85}};
      s[k] = 8'hFF;
      t[(k + 1) % FIELDS] = 8'hFF;
      send_levels(s, t);
    end
    wait_drained();
  endtask

  task automatic test_random_groups(int count, int gaps, int stalls);
    gap_pct   = gaps;
    stall_pct = stalls;
    for (int n = 0; n < count; n++) send_group(random_group());
  endtask

  // The result side holds off long enough for the pipeline to fill and
  // push back on the input, then everything drains before moving on.
  task automatic test_output_holdoff();
    gap_pct   = 0;
    stall_pct = 0;
    hold_left = 150;
    for (int n = 0; n < 40; n++) send_group(random_group());
    wait_drained();
  endtask

  initial begin
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_corner_groups();
    test_random_groups(250, 0, 0);
    test_random_groups(230, 80, 0);
    test_random_groups(230, 0, 80);
    test_output_holdoff();
    test_random_groups(250, 7, 7);
    wait_drained();
    repeat (NSTG + 6) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_emitter_group_recolor OK");
    end else begin
      $display("tb_emitter_group_recolor NOT OK");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("tb_emitter_group_recolor NOT OK");
    $finish;
  end

endmodule
